// ===== sv/tgr_pkg.sv =====
// Shared types, constants and palette for the text glyph rasterizer.
`timescale 1ns / 1ps
package tgr_pkg;

  localparam int GLYPH_ROWS_DEF = 16;
  localparam int FONT_CHARS_DEF = 256;

  // Field widths fixed by the item formats
  localparam int FONT_INDEX_W = 12;
  localparam int CELL_W       = 16;
  localparam int COLS_W       = 9;
  localparam int WIDTH_W      = 13;
  localparam int ADDR_W       = 24;
  localparam int PIX_W        = 16;
  localparam int GROUP_W      = 64;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 24;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_COLUMNS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_BASE   = 2'd2;

  localparam logic [COLS_W-1:0]  TEXT_COLUMNS_RST = 9'd80;
  localparam logic [WIDTH_W-1:0] SCREEN_WIDTH_RST = 13'd640;
  localparam logic [ADDR_W-1:0]  FRAME_BASE_RST   = 24'd0;

  // Item commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  localparam logic [7:0] SPACE_CODE = 8'd32;

  typedef logic [PIX_W-1:0] pix_t;

  // Pack an 8-bit-per-channel color into RGB565 with red in the low bits
  function automatic pix_t pal565(input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b);
    return {b[7:3], g[7:2], r[7:3]};
  endfunction

  localparam pix_t PALETTE [16] = '{
    pal565(8'd0,   8'd0,   8'd0),   pal565(8'd222, 8'd56,  8'd43),
    pal565(8'd0,   8'd187, 8'd0),   pal565(8'd255, 8'd199, 8'd6),
    pal565(8'd0,   8'd111, 8'd184), pal565(8'd118, 8'd38,  8'd113),
    pal565(8'd44,  8'd181, 8'd233), pal565(8'd187, 8'd187, 8'd187),
    pal565(8'd85,  8'd85,  8'd85),  pal565(8'd255, 8'd0,   8'd0),
    pal565(8'd85,  8'd255, 8'd85),  pal565(8'd255, 8'd255, 8'd85),
    pal565(8'd0,   8'd0,   8'd255), pal565(8'd255, 8'd0,   8'd255),
    pal565(8'd0,   8'd255, 8'd255), pal565(8'd255, 8'd255, 8'd255)
  };

endpackage

// ===== sv/tgr_if.sv =====
// Valid/ready channel interfaces for request and result items.
`timescale 1ns / 1ps
interface tgr_in_if;
  import tgr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [FONT_INDEX_W-1:0] font_index;
  logic [7:0]              font_byte;
  logic [CELL_W-1:0]       cell_position;
  logic [7:0]              char_code;
  logic [3:0]              fg_color;
  logic [3:0]              bg_color;

  modport source (output valid, cmd, font_index, font_byte, cell_position, char_code,
                  fg_color, bg_color, input ready);
  modport sink (input valid, cmd, font_index, font_byte, cell_position, char_code,
                fg_color, bg_color, output ready);
endinterface

interface tgr_out_if;
  import tgr_pkg::*;
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  pixel_address;
  logic [GROUP_W-1:0] pixel_group;
  logic               last_of_cell;

  modport source (output valid, pixel_address, pixel_group, last_of_cell, input ready);
  modport sink (input valid, pixel_address, pixel_group, last_of_cell, output ready);
endinterface

// ===== sv/tgr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/tgr_divider.sv =====
// Restoring divider, one quotient bit per cycle, for cell index over column count.
`timescale 1ns / 1ps
module tgr_divider
  import tgr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CELL_W-1:0] dividend,
  input  logic [COLS_W-1:0] divisor,
  output logic [CELL_W-1:0] quotient,
  output logic [COLS_W-1:0] remainder,
  output logic              done
);

  localparam int CNT_W = $clog2(CELL_W);

  logic [COLS_W-1:0] div_reg;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [COLS_W:0]   trial;
  logic              ge;

  assign trial = {remainder, quotient[CELL_W-1]};
  assign ge    = trial >= {1'b0, div_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(CELL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_reg   <= divisor;
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[CELL_W-2:0], ge};
      remainder <= ge ? COLS_W'(trial - {1'b0, div_reg}) : trial[COLS_W-1:0];
    end
  end

endmodule

// ===== sv/text_glyph_rasterizer_unit.sv =====
// A load item is written to the font store on acceptance, and the block stays ready.
// A draw item passes through the divider, a step that latches quotient and remainder,
// the address multiply with the row 0 fetch, and the output register load, then gives
// 2*GLYPH_ROWS results at one per cycle while the sink is ready. No new item is taken
// until the last result of a draw has been loaded into the output register.
// Reset (rst, synchronous) restores the config registers and idles the sequencer;
// the font store is not cleared and holds whatever was last written.
`timescale 1ns / 1ps
module text_glyph_rasterizer_unit
  import tgr_pkg::*;
#(
  parameter int GLYPH_ROWS = GLYPH_ROWS_DEF,
  parameter int FONT_CHARS = FONT_CHARS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  tgr_in_if.sink                 request,
  tgr_out_if.source              result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DEPTH = FONT_CHARS * GLYPH_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(GLYPH_ROWS);
  localparam int CW    = $clog2(FONT_CHARS);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state;

  // Configuration registers
  logic [COLS_W-1:0]  text_columns;
  logic [WIDTH_W-1:0] screen_width_pixels;
  logic [ADDR_W-1:0]  frame_base_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_columns        <= TEXT_COLUMNS_RST;
      screen_width_pixels <= SCREEN_WIDTH_RST;
      frame_base_address  <= FRAME_BASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEXT_COLUMNS: text_columns        <= cfg_data[COLS_W-1:0];
        CFG_SCREEN_WIDTH: screen_width_pixels <= cfg_data[WIDTH_W-1:0];
        CFG_FRAME_BASE:   frame_base_address  <= cfg_data[ADDR_W-1:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // Input handshake: take an item only while the sequencer is idle
  logic accept, accept_load, accept_draw;

  assign request.ready = (state == ST_IDLE);
  assign accept        = request.valid && request.ready;
  assign accept_load   = accept && (request.cmd == CMD_LOAD);
  assign accept_draw   = accept && (request.cmd == CMD_DRAW);

  // Character code: zero draws as a space, then wrap into the font size.
  // The code is below 256 and the font holds at least 128 characters, so one
  // compare and subtract covers the wrap.
  logic [7:0] code_sel;
  logic [9:0] code_wrap;
  logic [CW-1:0] code_eff;

  always_comb begin
    code_sel  = (request.char_code == 8'd0) ? SPACE_CODE : request.char_code;
    code_wrap = {2'b00, code_sel};
    if (code_wrap >= 10'(FONT_CHARS)) begin
      code_wrap = code_wrap - 10'(FONT_CHARS);
    end
    code_eff = CW'(code_wrap);
  end

  // Divider: cell index over column count, zero columns acting as one
  logic [COLS_W-1:0] cols_eff;
  logic [CELL_W-1:0] div_quo;
  logic [COLS_W-1:0] div_rem;
  logic              div_done;

  assign cols_eff = (text_columns == '0) ? COLS_W'(1) : text_columns;

  tgr_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (accept_draw),
    .dividend  (request.cell_position),
    .divisor   (cols_eff),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  // Per-cell working registers
  logic [AW-1:0]     glyph_base;
  pix_t              fg_pix, bg_pix;
  logic [ADDR_W-1:0] row_pix;
  logic [ADDR_W-1:0] col_off;
  logic [ADDR_W-1:0] line_addr;
  logic [RW-1:0]     row;
  logic [RW-1:0]     row_next;
  logic              half;
  logic              is_last;

  assign row_next = row + 1'b1;
  assign is_last  = (row == RW'(GLYPH_ROWS - 1)) && half;

  // Font store
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          load_out;

  assign ram_we = accept_load && (32'(request.font_index) < DEPTH);

  tgr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_font (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(request.font_index)),
    .wdata (request.font_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register loads in the emit state whenever it is empty or being drained
  assign load_out = (state == ST_EMIT) && (!result.valid || result.ready);

  // Fetch glyph row 0 during setup; fetch the next row as the right half of the
  // current one moves out, so the RAM data is ready for the next left half.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = glyph_base;
    if (state == ST_MUL) begin
      ram_re = 1'b1;
    end else if (load_out && half && !is_last) begin
      ram_re    = 1'b1;
      ram_raddr = glyph_base + AW'(row_next);
    end
  end

  // Expand four glyph bits to pixels, leftmost pixel in the low word
  logic [3:0]         nibble;
  logic [GROUP_W-1:0] group;

  always_comb begin
    nibble = half ? ram_rdata[3:0] : ram_rdata[7:4];
    for (int k = 0; k < 4; k++) begin
      group[PIX_W*k +: PIX_W] = nibble[3-k] ? fg_pix : bg_pix;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result.valid <= 1'b0;
      row          <= '0;
      half         <= 1'b0;
    end else begin
      // Raise valid on a new item, drop it once the held item is taken
      if (load_out) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept_draw) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          row   <= '0;
          half  <= 1'b0;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (load_out) begin
            half <= !half;
            if (half) begin
              row <= row_next;
            end
            if (is_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers: no reset needed
  always_ff @(posedge clk) begin
    if (accept_draw) begin
      glyph_base <= AW'(32'(code_eff) * GLYPH_ROWS);
      fg_pix     <= PALETTE[request.fg_color];
      bg_pix     <= PALETTE[request.bg_color];
    end
    if (state == ST_DIV && div_done) begin
      row_pix <= ADDR_W'(32'(div_quo) * GLYPH_ROWS);
      col_off <= ADDR_W'({div_rem, 3'b000});
    end
    if (state == ST_MUL) begin
      // base + width * y0 + x0, kept modulo 2^24
      line_addr <= frame_base_address + col_off
                 + ADDR_W'({{ADDR_W{1'b0}}, screen_width_pixels} * {13'd0, row_pix});
    end
    if (load_out) begin
      result.pixel_address <= half ? line_addr + ADDR_W'(4) : line_addr;
      result.pixel_group   <= group;
      result.last_of_cell  <= is_last;
      if (half) begin
        line_addr <= line_addr + ADDR_W'(screen_width_pixels);
      end
    end
  end

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the text glyph rasterizer: font loads, cell draws, checks.
`timescale 1ns / 1ps
module tb;
  import tgr_pkg::*;

  localparam int GLYPH_ROWS    = GLYPH_ROWS_DEF;
  localparam int SETTLE_CYCLES = 60;
  // Index past the last real register; writes to it must change nothing
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic                    cmd;
    logic [FONT_INDEX_W-1:0] font_index;
    logic [7:0]              font_byte;
    logic [CELL_W-1:0]       cell_position;
    logic [7:0]              char_code;
    logic [3:0]              fg_color;
    logic [3:0]              bg_color;
  } cell_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [GROUP_W-1:0] pixels;
    logic               last;
  } pixel_group_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Everything the bench drives starts at a known value
  cell_req_t              req_now   = '0;
  logic                   req_valid = 1'b0;
  logic                   res_ready = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // Idling knobs, changed only at falling edges
  logic gaps_on   = 1'b0;
  logic stalls_on = 1'b0;

  tgr_in_if  req_ch ();
  tgr_out_if res_ch ();

  assign req_ch.valid         = req_valid;
  assign req_ch.cmd           = req_now.cmd;
  assign req_ch.font_index    = req_now.font_index;
  assign req_ch.font_byte     = req_now.font_byte;
  assign req_ch.cell_position = req_now.cell_position;
  assign req_ch.char_code     = req_now.char_code;
  assign req_ch.fg_color      = req_now.fg_color;
  assign req_ch.bg_color      = req_now.bg_color;
  assign res_ch.ready         = res_ready;

  text_glyph_rasterizer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .request   (req_ch),
    .result    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bench copy of the block: register shadows and the font store as loaded
  logic [COLS_W-1:0]  text_cols  = TEXT_COLUMNS_RST;
  logic [WIDTH_W-1:0] row_pitch  = SCREEN_WIDTH_RST;
  logic [ADDR_W-1:0]  frame_base = FRAME_BASE_RST;
  logic [7:0]         font_copy [FONT_CHARS_DEF*GLYPH_ROWS_DEF];

  // Rows queued for loading so far; a glyph is drawable once all its rows are set
  logic [FONT_CHARS_DEF*GLYPH_ROWS_DEF-1:0] font_written = '0;

  cell_req_t    pending_items [$];
  pixel_group_t pixel_groups_due [$];
  pixel_group_t want;
  int unsigned  mismatches = 0;
  int unsigned  send_gap   = 0;
  int unsigned  stall_left = 0;

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic pix_t rgb565(input int r, input int g, input int b);
    return 16'((r / 8) | ((g / 4) << 5) | ((b / 8) << 11));
  endfunction

  function automatic pix_t ansi_color(input logic [3:0] idx);
    case (idx)
      4'd0:    return rgb565(0, 0, 0);
      4'd1:    return rgb565(222, 56, 43);
      4'd2:    return rgb565(0, 187, 0);
      4'd3:    return rgb565(255, 199, 6);
      4'd4:    return rgb565(0, 111, 184);
      4'd5:    return rgb565(118, 38, 113);
      4'd6:    return rgb565(44, 181, 233);
      4'd7:    return rgb565(187, 187, 187);
      4'd8:    return rgb565(85, 85, 85);
      4'd9:    return rgb565(255, 0, 0);
      4'd10:   return rgb565(85, 255, 85);
      4'd11:   return rgb565(255, 255, 85);
      4'd12:   return rgb565(0, 0, 255);
      4'd13:   return rgb565(255, 0, 255);
      4'd14:   return rgb565(0, 255, 255);
      default: return rgb565(255, 255, 255);
    endcase
  endfunction

  // Apply one accepted item: store a font byte, or queue the 32 groups of a cell
  task automatic render_request(input cell_req_t it);
    logic [7:0]         code;
    logic [COLS_W-1:0]  cols;
    logic [63:0]        col, row, line_addr;
    logic [7:0]         bits;
    pix_t               fg, bg;
    pixel_group_t       g;
    if (it.cmd == CMD_LOAD) begin
      font_copy[it.font_index] = it.font_byte;
    end else begin
      // A zero code draws as a space; a zero column count acts as one column
      code = (it.char_code == 8'd0) ? SPACE_CODE : it.char_code;
      cols = (text_cols == '0) ? COLS_W'(1) : text_cols;
      col  = 64'(it.cell_position % cols);
      row  = 64'(it.cell_position / cols);
      fg   = ansi_color(it.fg_color);
      bg   = ansi_color(it.bg_color);
      for (int y = 0; y < GLYPH_ROWS; y++) begin
        bits = font_copy[int'(code) * GLYPH_ROWS + y];
        line_addr = 64'(frame_base) + 64'(row_pitch) * (row * GLYPH_ROWS + 64'(y)) + col * 8;
        for (int h = 0; h < 2; h++) begin
          g.addr   = line_addr[ADDR_W-1:0] + ADDR_W'(4 * h);
          g.pixels = '0;
          for (int k = 0; k < 4; k++)
            g.pixels[16*k +: 16] = bits[7 - (4*h + k)] ? fg : bg;
          g.last = (y == GLYPH_ROWS - 1) && (h == 1);
          pixel_groups_due.push_back(g);
        end
      end
    end
  endtask

  // Sender: advance to the next pending item once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap  <= 0;
    end else if (!req_valid || req_ch.ready) begin
      if (send_gap != 0) begin
        req_valid <= 1'b0;
        send_gap  <= send_gap - 1;
      end else if (pending_items.size() != 0) begin
        req_now   <= pending_items.pop_front();
        req_valid <= 1'b1;
        send_gap  <= gaps_on ? idle_len() : 0;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver: hold ready low through random stalls
  always @(posedge clk) begin
    if (rst) begin
      res_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      res_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      res_ready <= 1'b1;
      if (stalls_on && $urandom_range(0, 7) == 0) stall_left <= idle_len();
    end
  end

  // Monitor: predict on every accepted request, check every accepted result
  always @(posedge clk) begin
    if (!rst && req_valid && req_ch.ready) render_request(req_now);
    if (!rst && res_ch.valid && res_ready) begin
      if (pixel_groups_due.size() == 0) begin
        $error("result item with nothing expected: address %h group %h",
               res_ch.pixel_address, res_ch.pixel_group);
        mismatches++;
      end else begin
        want = pixel_groups_due.pop_front();
        if (res_ch.pixel_address !== want.addr) begin
          $error("pixel_address expected %h actual %h", want.addr, res_ch.pixel_address);
          mismatches++;
        end
        if (res_ch.pixel_group !== want.pixels) begin
          $error("pixel_group expected %h actual %h", want.pixels, res_ch.pixel_group);
          mismatches++;
        end
        if (res_ch.last_of_cell !== want.last) begin
          $error("last_of_cell expected %b actual %b", want.last, res_ch.last_of_cell);
          mismatches++;
        end
      end
    end
  end

  // Queue one font byte; the draw-only fields carry noise
  task automatic queue_load(input logic [FONT_INDEX_W-1:0] idx, input logic [7:0] val);
    cell_req_t it;
    it.cmd           = CMD_LOAD;
    it.font_index    = idx;
    it.font_byte     = val;
    it.cell_position = CELL_W'($urandom);
    it.char_code     = 8'($urandom);
    it.fg_color      = 4'($urandom);
    it.bg_color      = 4'($urandom);
    font_written[idx] = 1'b1;
    pending_items.push_back(it);
  endtask

  // Queue one cell draw; the load-only fields carry noise
  task automatic queue_draw(input logic [7:0] code, input logic [CELL_W-1:0] pos,
                            input logic [3:0] fg, input logic [3:0] bg);
    cell_req_t it;
    it.cmd           = CMD_DRAW;
    it.font_index    = FONT_INDEX_W'($urandom);
    it.font_byte     = 8'($urandom);
    it.cell_position = pos;
    it.char_code     = code;
    it.fg_color      = fg;
    it.bg_color      = bg;
    pending_items.push_back(it);
  endtask

  // Load every row of one glyph with random bits
  task automatic queue_glyph(input logic [7:0] code);
    for (int y = 0; y < GLYPH_ROWS; y++)
      queue_load(FONT_INDEX_W'(int'(code) * GLYPH_ROWS + y), 8'($urandom));
  endtask

  // Pick among fully loaded glyphs only, so no unwritten font entry is ever read
  function automatic logic [7:0] pick_ready_code();
    logic [7:0] ready_codes [$];
    logic [7:0] pick;
    for (int c = 0; c < FONT_CHARS_DEF; c++)
      if (&font_written[c*GLYPH_ROWS +: GLYPH_ROWS]) ready_codes.push_back(8'(c));
    pick = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
    // Sometimes ask for the space through the zero code
    if (pick == SPACE_CODE && $urandom_range(0, 2) == 0) pick = 8'd0;
    return pick;
  endfunction

  // Random traffic: whole glyph loads, stray font bytes and many draws
  task automatic queue_random(input int count);
    int added;
    int unsigned r;
    logic [CELL_W-1:0] pos;
    added = 0;
    while (added < count) begin
      r = $urandom_range(0, 99);
      if (r < 10 && count - added >= GLYPH_ROWS) begin
        queue_glyph(8'($urandom));
        added += GLYPH_ROWS;
      end else if (r < 30) begin
        queue_load(FONT_INDEX_W'($urandom), 8'($urandom));
        added++;
      end else begin
        // Half the cells near the top left, half anywhere in the index range
        pos = $urandom_range(0, 1) ? CELL_W'($urandom) : CELL_W'($urandom_range(0, 700));
        queue_draw(pick_ready_code(), pos, 4'($urandom), 4'($urandom));
        added++;
      end
    end
  endtask

  // Wait until every item is taken and every result is in, then let the block settle
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || req_valid || pixel_groups_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers plus the spare index, one write per edge
  task automatic program_regs(input logic [COLS_W-1:0] cols, input logic [WIDTH_W-1:0] width,
                              input logic [ADDR_W-1:0] base);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TEXT_COLUMNS;
    cfg_data  <= CFG_DATA_W'(cols);
    @(posedge clk);
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_data  <= CFG_DATA_W'(width);
    @(posedge clk);
    cfg_index <= CFG_FRAME_BASE;
    cfg_data  <= base;
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_data  <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
    text_cols  = cols;
    row_pitch  = width;
    frame_base = base;
  endtask

  task automatic set_idling(input logic gaps, input logic stalls);
    @(negedge clk);
    gaps_on   = gaps;
    stalls_on = stalls;
  endtask

  initial begin
    logic [7:0] corner_rows [8];
    corner_rows = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hF0, 8'h0F};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset settings, no idling: the space glyph with corner
    // patterns, then draws at the first and last cell index, across the end of a text line and at palette ends
    set_idling(1'b0, 1'b0);
    for (int y = 0; y < GLYPH_ROWS; y++)
      queue_load(FONT_INDEX_W'(int'(SPACE_CODE) * GLYPH_ROWS + y),
                 (y < 8) ? corner_rows[y] : 8'($urandom));
    queue_draw(8'd0, 16'd0, 4'd15, 4'd0);
    queue_draw(SPACE_CODE, 16'hFFFF, 4'd0, 4'd15);
    queue_draw(SPACE_CODE, 16'd79, 4'd7, 4'd7);
    queue_draw(8'd0, 16'd80, 4'd9, 4'd12);
    wait_drained();

    // Zero columns act as one, narrowest pitch, base at the top so addresses wrap
    program_regs('0, WIDTH_W'(8), 24'hFFFFFF);
    set_idling(1'b1, 1'b1);
    queue_glyph(8'hFF);
    queue_random(10);
    wait_drained();

    // Widest legal layout with wrap near the top of the address space
    program_regs(COLS_W'(256), WIDTH_W'(4096), 24'hFFF000);
    set_idling(1'b0, 1'b1);
    queue_random(26);
    wait_drained();

    // One column and the largest pitch the field holds
    program_regs(COLS_W'(1), '1, '0);
    set_idling(1'b1, 1'b0);
    queue_random(26);
    wait_drained();

    // Random settings; halfway through, hold the sender until all results are in
    program_regs(COLS_W'($urandom), WIDTH_W'($urandom), ADDR_W'($urandom));
    set_idling(1'b1, 1'b1);
    queue_random(13);
    wait_drained();
    queue_random(13);
    wait_drained();

    // Largest column field, zero pitch, base in mid range
    program_regs('1, '0, 24'h800000);
    set_idling(1'b1, 1'b1);
    queue_random(26);
    wait_drained();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
